>>> hdl/lcdtw_pkg.sv
// Package for the text line writer: write and queue entry types, display
// command constants and the row-jump helper functions.
// No dependencies.
package lcdtw_pkg;

   localparam int unsigned MAX_WRITES = 3;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic DATA_WRITE = 1'b1;

   localparam logic [7:0] MODE_CMD    = 8'h30;
   localparam logic [7:0] PAD_SPACE   = 8'h20;
   localparam logic [7:0] WIDE_LIMIT  = 8'h80;
   localparam logic [2:0] ADDR_PREFIX = 3'b100;

   typedef struct packed {
      logic       is_data;
      logic [7:0] bus_byte;
   } write_type;

   typedef struct packed {
      logic [1:0]                 last_slot;
      write_type [MAX_WRITES-1:0] slots;
   } entry_type;

   function automatic logic [7:0] row_base(input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0:    b = 8'h80;
         2'd1:    b = 8'h90;
         2'd2:    b = 8'h88;
         default: b = 8'h98;
      endcase
      return b;
   endfunction

   // t = count + 2*column, not wrapped to 8 bits
   function automatic logic [8:0] jump_pos(input logic [7:0] cnt, input logic [2:0] col);
      return {1'b0, cnt} + {5'b0, col, 1'b0};
   endfunction

   function automatic logic jump_hit(input logic [7:0] cnt, input logic [2:0] col);
      logic [8:0] t;
      t = jump_pos(cnt, col);
      return (t[3:0] == 4'd0);
   endfunction

   function automatic logic [7:0] jump_byte(input logic [7:0] cnt, input logic [2:0] col,
                                            input logic [1:0] row);
      logic [8:0] t;
      t = jump_pos(cnt, col);
      return row_base(row + t[5:4]);
   endfunction

endpackage

>>> hdl/lcdtw_if.sv
// Channel interfaces for the text line writer: text byte requests and
// display write responses. Depends on nothing.
interface lcdtw_req_if;
   logic       valid;
   logic       ready;
   logic       first_of_string;
   logic [1:0] start_row;
   logic [2:0] start_column;
   logic [7:0] char_code;

   modport source (output valid, first_of_string, start_row, start_column, char_code,
                   input ready);
   modport sink   (input valid, first_of_string, start_row, start_column, char_code,
                   output ready);
endinterface

interface lcdtw_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_data;
   logic [7:0] bus_byte;
   logic       last;

   modport source (output valid, is_data, bus_byte, last, input ready);
   modport sink   (input valid, is_data, bus_byte, last, output ready);
endinterface

>>> hdl/lcdtw_front.sv
// Front end: accepts text bytes, keeps string state, and builds the list of
// display writes for each byte. Depends on lcdtw_pkg and lcdtw_req_if.
module lcdtw_front (
   input  logic               clock,
   input  logic               reset,
   lcdtw_req_if.sink          req_chan,
   input  logic               push_ready,
   output logic               push_valid,
   output lcdtw_pkg::entry_type push_entry
);

   logic [7:0] cnt_ff, cnt_in;
   logic [7:0] prev_ff, prev_in;
   logic [1:0] row_ff, row_in;
   logic [2:0] col_ff, col_in;

   logic       accept;
   logic [7:0] cnt_cur, cnt_a, cnt_b;
   logic [7:0] prev_cur;
   logic       pad;
   logic [1:0] k;
   lcdtw_pkg::write_type [lcdtw_pkg::MAX_WRITES-1:0] slots;

   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid;
   assign accept         = req_chan.valid && push_ready;

   always_comb begin
      cnt_cur  = req_chan.first_of_string ? 8'd0 : cnt_ff;
      prev_cur = req_chan.first_of_string ? 8'd0 : prev_ff;
      row_in   = req_chan.first_of_string ? req_chan.start_row : row_ff;
      col_in   = req_chan.first_of_string ? req_chan.start_column : col_ff;

      slots = '0;
      k     = 2'd0;
      if (req_chan.first_of_string) begin
         slots[0] = '{is_data: lcdtw_pkg::CMD_WRITE, bus_byte: lcdtw_pkg::MODE_CMD};
         slots[1] = '{is_data: lcdtw_pkg::CMD_WRITE,
                      bus_byte: {lcdtw_pkg::ADDR_PREFIX, req_chan.start_row[0],
                                 req_chan.start_row[1], req_chan.start_column}};
         k = 2'd2;
      end

      pad = cnt_cur[0] && (prev_cur <= lcdtw_pkg::WIDE_LIMIT) &&
            (req_chan.char_code > lcdtw_pkg::WIDE_LIMIT);
      cnt_a = cnt_cur + {7'd0, pad};
      if (pad) begin
         slots[k] = '{is_data: lcdtw_pkg::DATA_WRITE, bus_byte: lcdtw_pkg::PAD_SPACE};
         k = k + 2'd1;
         if (lcdtw_pkg::jump_hit(cnt_a, col_in)) begin
            slots[k] = '{is_data: lcdtw_pkg::CMD_WRITE,
                         bus_byte: lcdtw_pkg::jump_byte(cnt_a, col_in, row_in)};
            k = k + 2'd1;
         end
      end

      slots[k] = '{is_data: lcdtw_pkg::DATA_WRITE, bus_byte: req_chan.char_code};
      k = k + 2'd1;
      cnt_b = cnt_a + 8'd1;
      if (lcdtw_pkg::jump_hit(cnt_b, col_in)) begin
         slots[k] = '{is_data: lcdtw_pkg::CMD_WRITE,
                      bus_byte: lcdtw_pkg::jump_byte(cnt_b, col_in, row_in)};
         k = k + 2'd1;
      end

      cnt_in  = cnt_b;
      prev_in = req_chan.char_code;
   end

   assign push_entry.slots     = slots;
   assign push_entry.last_slot = k - 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         prev_ff <= '0;
         row_ff  <= '0;
         col_ff  <= '0;
      end else if (accept) begin
         cnt_ff  <= cnt_in;
         prev_ff <= prev_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

endmodule

>>> hdl/lcdtw_queue.sv
// Two-entry queue of write lists between front and back ends.
// Depends on lcdtw_pkg.
module lcdtw_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  lcdtw_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop,
   output lcdtw_pkg::entry_type pop_entry
);

   lcdtw_pkg::entry_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> hdl/lcdtw_back.sv
// Back end: steps through the queued write list one write per cycle into
// the response register, unless stalled. Uses lcdtw_pkg and lcdtw_rsp_if.
module lcdtw_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  lcdtw_pkg::entry_type head_entry,
   output logic                pop,
   lcdtw_rsp_if.source         rsp_chan
);

   logic                 vld_ff, vld_in;
   logic [1:0]           idx_ff, idx_in;
   lcdtw_pkg::write_type out_ff, out_in;
   logic                 last_ff, last_in;
   logic                 advance, at_last;
   lcdtw_pkg::write_type sel;

   always_comb begin
      unique case (idx_ff)
         2'd0:    sel = head_entry.slots[0];
         2'd1:    sel = head_entry.slots[1];
         default: sel = head_entry.slots[2];
      endcase
   end

   assign advance = head_valid && (!vld_ff || rsp_chan.ready);
   assign at_last = (idx_ff == head_entry.last_slot);
   assign pop     = advance && at_last;

   always_comb begin
      out_in  = sel;
      last_in = at_last;
      idx_in  = idx_ff;
      vld_in  = vld_ff;
      if (advance) begin
         vld_in = 1'b1;
         idx_in = at_last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_chan.ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff  <= out_in;
         last_ff <= last_in;
      end
   end

   assign rsp_chan.valid    = vld_ff;
   assign rsp_chan.is_data  = out_ff.is_data;
   assign rsp_chan.bus_byte = out_ff.bus_byte;
   assign rsp_chan.last     = last_ff;

endmodule

>>> hdl/lcd_text_line_writer_unit.sv
// Top level of the text line writer: front end, write-list queue, back end.
// Depends on lcdtw_pkg, lcdtw_if, lcdtw_front, lcdtw_queue, lcdtw_back.
//
//   channel    dir   handshake      payload
//   req_chan   in    valid/ready    first_of_string, start_row, start_column, char_code
//   rsp_chan   out   valid/ready    is_data, bus_byte, last
//
// Each text byte yields one to three writes; the back end issues one write per
// cycle while rsp_chan is not stalled, through the single response register.
// Requests are taken while the two-entry queue has room, also during output stalls.
// An accepted request is registered in the queue, then in the response register.
// Synchronous active-high reset clears string state, queue and output valid.
module lcd_text_line_writer_unit (
   input  logic         clock,
   input  logic         reset,
   lcdtw_req_if.sink    req_chan,
   lcdtw_rsp_if.source  rsp_chan
);

   logic                 push_valid, push_ready;
   lcdtw_pkg::entry_type push_entry;
   logic                 head_valid, pop;
   lcdtw_pkg::entry_type head_entry;

   lcdtw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   lcdtw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (head_valid),
      .pop        (pop),
      .pop_entry  (head_entry)
   );

   lcdtw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

>>> hdl/lcdtw_checker.sv
// Port-level checks for the text line writer, bound to the top level.
// Depends on lcdtw_pkg and lcd_text_line_writer_unit.
module lcdtw_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_is_data,
   input logic [7:0] rsp_bus_byte,
   input logic       rsp_last
);

   // output held under backpressure
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bus_byte) &&
                                  $stable(rsp_is_data) && $stable(rsp_last))
      else $error("rsp changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // mode command always precedes the address command
   a_mode_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_data == lcdtw_pkg::CMD_WRITE &&
      rsp_bus_byte == lcdtw_pkg::MODE_CMD |-> !rsp_last)
      else $error("mode command marked last");

   // only a row jump can end a byte's writes as a command
   a_last_cmd_is_jump: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && rsp_is_data == lcdtw_pkg::CMD_WRITE |->
      rsp_bus_byte == 8'h80 || rsp_bus_byte == 8'h90 ||
      rsp_bus_byte == 8'h88 || rsp_bus_byte == 8'h98)
      else $error("last command is not a row jump");

endmodule

bind lcd_text_line_writer_unit lcdtw_checker u_lcdtw_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_is_data  (rsp_chan.is_data),
   .rsp_bus_byte (rsp_chan.bus_byte),
   .rsp_last     (rsp_chan.last)
);

>>> test/tb_lcd_text_line_writer_unit.sv
// Testbench for lcd_text_line_writer_unit: directed table plus random text strings,
// each request checked write by write against typed-in writes or a model of the writer.
// Depends on lcdtw_pkg, lcdtw_if and the lcd_text_line_writer_unit RTL.
module tb_lcd_text_line_writer_unit;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned RANDOM_ITEMS = 160;
   localparam lcdtw_pkg::write_type NO_WRITE = '0;
   localparam logic [7:0] ROW_JUMP [4] = '{8'h80, 8'h90, 8'h88, 8'h98};

   typedef struct packed {
      logic                            first;
      logic [1:0]                      row;
      logic [2:0]                      col;
      logic [7:0]                      chr;
      logic [1:0]                      nfix;
      lcdtw_pkg::write_type [0:2]      fix;
   } text_row_type;

   typedef struct packed {
      logic       is_data;
      logic [7:0] bus_byte;
      logic       last;
   } disp_write_type;

   // nfix != 0: expected writes typed in; otherwise the model decides
   localparam text_row_type TEXT_TABLE [20] = '{
      '{1'b0, 2'd3, 3'd5, 8'h41, 2'd1,
        {{lcdtw_pkg::DATA_WRITE, 8'h41}, NO_WRITE, NO_WRITE}},
      '{1'b0, 2'd0, 3'd0, 8'hA1, 2'd2,
        {{lcdtw_pkg::DATA_WRITE, lcdtw_pkg::PAD_SPACE}, {lcdtw_pkg::DATA_WRITE, 8'hA1},
         NO_WRITE}},
      '{1'b0, 2'd1, 3'd2, 8'h00, 2'd1,
        {{lcdtw_pkg::DATA_WRITE, 8'h00}, NO_WRITE, NO_WRITE}},
      '{1'b1, 2'd0, 3'd0, 8'h30, 2'd3,
        {{lcdtw_pkg::CMD_WRITE, lcdtw_pkg::MODE_CMD}, {lcdtw_pkg::CMD_WRITE, 8'h80},
         {lcdtw_pkg::DATA_WRITE, 8'h30}}},
      '{1'b1, 2'd3, 3'd7, 8'hFF, 2'd3,
        {{lcdtw_pkg::CMD_WRITE, lcdtw_pkg::MODE_CMD}, {lcdtw_pkg::CMD_WRITE, 8'h9F},
         {lcdtw_pkg::DATA_WRITE, 8'hFF}}},
      '{1'b0, 2'd0, 3'd0, 8'h80, 2'd2,
        {{lcdtw_pkg::DATA_WRITE, 8'h80}, {lcdtw_pkg::CMD_WRITE, 8'h80}, NO_WRITE}},
      '{1'b0, 2'd2, 3'd1, 8'h81, 2'd0, '0},
      '{1'b1, 2'd2, 3'd7, 8'h61, 2'd3,
        {{lcdtw_pkg::CMD_WRITE, lcdtw_pkg::MODE_CMD}, {lcdtw_pkg::CMD_WRITE, 8'h8F},
         {lcdtw_pkg::DATA_WRITE, 8'h61}}},
      '{1'b0, 2'd0, 3'd0, 8'hC0, 2'd3,
        {{lcdtw_pkg::DATA_WRITE, lcdtw_pkg::PAD_SPACE}, {lcdtw_pkg::CMD_WRITE, 8'h98},
         {lcdtw_pkg::DATA_WRITE, 8'hC0}}},
      '{1'b0, 2'd0, 3'd0, 8'hC1, 2'd0, '0},
      '{1'b1, 2'd1, 3'd3, 8'hB0, 2'd3,
        {{lcdtw_pkg::CMD_WRITE, lcdtw_pkg::MODE_CMD}, {lcdtw_pkg::CMD_WRITE, 8'h93},
         {lcdtw_pkg::DATA_WRITE, 8'hB0}}},
      '{1'b0, 2'd3, 3'd7, 8'h7F, 2'd0, '0},
      '{1'b0, 2'd0, 3'd0, 8'h01, 2'd0, '0},
      '{1'b0, 2'd0, 3'd0, 8'h80, 2'd0, '0},
      '{1'b0, 2'd0, 3'd0, 8'h80, 2'd0, '0},
      '{1'b0, 2'd0, 3'd0, 8'h81, 2'd0, '0},
      '{1'b1, 2'd0, 3'd7, 8'h41, 2'd0, '0},
      '{1'b0, 2'd0, 3'd0, 8'h42, 2'd0, '0},
      '{1'b1, 2'd1, 3'd7, 8'hE0, 2'd0, '0},
      '{1'b0, 2'd0, 3'd0, 8'hE1, 2'd0, '0}
   };

   logic clock;
   logic reset;

   lcdtw_req_if req_bus ();
   lcdtw_rsp_if rsp_bus ();

   lcd_text_line_writer_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   text_row_type   text_bytes [$];
   disp_write_type pending_writes [$];
   disp_write_type calc_writes [$];
   disp_write_type due_write;

   logic [7:0] half_count;
   logic [7:0] prev_chr;
   logic [1:0] str_row;
   logic [2:0] str_col;

   int unsigned total_items;
   int unsigned sent_count;
   int unsigned writes_checked;
   int unsigned string_count;
   int unsigned pad_count;
   int unsigned jump_count;
   int unsigned error_count;
   int unsigned idle_cycles;
   int          k;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [7:0] pick_text_byte();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 40) return 8'($urandom_range(255, 129));
      if (roll < 48) return lcdtw_pkg::WIDE_LIMIT;
      return 8'($urandom_range(127, 1));
   endfunction

   function automatic int unsigned idle_pct(input bit sender_side);
      int unsigned phase;
      if (total_items == 0) return 0;
      phase = (sent_count * 3) / total_items;
      case (phase)
         0:       return sender_side ? 36 : 64;
         1:       return sender_side ? 64 : 36;
         default: return 0;
      endcase
   endfunction

   task automatic count_half_cell();
      logic [8:0] pos;
      logic [1:0] idx;
      half_count = half_count + 8'd1;
      pos = {1'b0, half_count} + {5'd0, str_col, 1'b0};
      if (pos[3:0] == 4'd0) begin
         idx = str_row + pos[5:4];
         calc_writes.push_back('{lcdtw_pkg::CMD_WRITE, ROW_JUMP[idx], 1'b0});
         jump_count++;
      end
   endtask

   task automatic predict_writes(input text_row_type t);
      calc_writes.delete();
      if (t.first) begin
         str_row = t.row;
         str_col = t.col;
         half_count = '0;
         prev_chr = '0;
         string_count++;
         calc_writes.push_back('{lcdtw_pkg::CMD_WRITE, lcdtw_pkg::MODE_CMD, 1'b0});
         // rows 2 and 3 sit 8 columns to the right of rows 0 and 1
         calc_writes.push_back('{lcdtw_pkg::CMD_WRITE,
                                 {lcdtw_pkg::ADDR_PREFIX, t.row[0], t.row[1], t.col},
                                 1'b0});
      end
      if (half_count[0] && prev_chr <= lcdtw_pkg::WIDE_LIMIT &&
          t.chr > lcdtw_pkg::WIDE_LIMIT) begin
         calc_writes.push_back('{lcdtw_pkg::DATA_WRITE, lcdtw_pkg::PAD_SPACE, 1'b0});
         pad_count++;
         count_half_cell();
      end
      calc_writes.push_back('{lcdtw_pkg::DATA_WRITE, t.chr, 1'b0});
      count_half_cell();
      prev_chr = t.chr;
      calc_writes[calc_writes.size()-1].last = 1'b1;
   endtask

   // request side: hold payload until taken, idle at random between requests
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_writes(text_bytes[0]);
            if (text_bytes[0].nfix != 2'd0) begin
               for (k = 0; k < int'(text_bytes[0].nfix); k++) begin
                  pending_writes.push_back('{text_bytes[0].fix[k].is_data,
                                             text_bytes[0].fix[k].bus_byte,
                                             k == int'(text_bytes[0].nfix) - 1});
               end
            end else begin
               foreach (calc_writes[i]) pending_writes.push_back(calc_writes[i]);
            end
            void'(text_bytes.pop_front());
            sent_count++;
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (text_bytes.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
               req_bus.valid <= 1'b1;
               req_bus.first_of_string <= text_bytes[0].first;
               req_bus.start_row <= text_bytes[0].row;
               req_bus.start_column <= text_bytes[0].col;
               req_bus.char_code <= text_bytes[0].chr;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_writes.size() == 0) begin
            $error("display write 0x%02h with none expected", rsp_bus.bus_byte);
            error_count++;
         end else begin
            due_write = pending_writes.pop_front();
            writes_checked++;
            if (rsp_bus.is_data !== due_write.is_data) begin
               $error("is_data: expected %0d, got %0d", due_write.is_data, rsp_bus.is_data);
               error_count++;
            end
            if (rsp_bus.bus_byte !== due_write.bus_byte) begin
               $error("bus_byte: expected 0x%02h, got 0x%02h",
                      due_write.bus_byte, rsp_bus.bus_byte);
               error_count++;
            end
            if (rsp_bus.last !== due_write.last) begin
               $error("last: expected %0d, got %0d", due_write.last, rsp_bus.last);
               error_count++;
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= idle_pct(1'b0));
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_lcd_text_line_writer_unit NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      text_row_type item;
      int unsigned  n_rand;
      int unsigned  len;
      bit           broken;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.first_of_string = 1'b0;
      req_bus.start_row = '0;
      req_bus.start_column = '0;
      req_bus.char_code = '0;
      rsp_bus.ready = 1'b0;
      half_count = '0;
      prev_chr = '0;
      str_row = '0;
      str_col = '0;
      sent_count = 0;
      writes_checked = 0;
      string_count = 0;
      pad_count = 0;
      jump_count = 0;
      error_count = 0;
      idle_cycles = 0;

      foreach (TEXT_TABLE[i]) text_bytes.push_back(TEXT_TABLE[i]);

      // mostly proper strings; some continue without a first byte
      n_rand = 0;
      while (n_rand < RANDOM_ITEMS) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
         broken = ($urandom_range(9) == 0);
         for (int j = 0; j < int'(len) && n_rand < RANDOM_ITEMS; j++) begin
            item = '0;
            item.first = (j == 0) && !broken;
            item.row = 2'($urandom_range(3));
            item.col = 3'($urandom_range(7));
            item.chr = pick_text_byte();
            text_bytes.push_back(item);
            n_rand++;
         end
      end
      total_items = text_bytes.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (text_bytes.size() != 0 || pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d text bytes in %0d strings, %0d display writes checked",
               sent_count, string_count, writes_checked);
      $display("with %0d padding spaces and %0d row jumps", pad_count, jump_count);
      if (error_count == 0) begin
         $display("tb_lcd_text_line_writer_unit OK");
      end else begin
         $display("tb_lcd_text_line_writer_unit NOT OK");
      end
      $finish;
   end

endmodule
